>>> design/rcem_pkg.sv
// Shared constants, register codes and types for the elliptical ROI crop.
`timescale 1ns / 1ps

package rcem_pkg;

    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CHANNELS   = 3;
    localparam int PIX_W      = 24;
    localparam int IDX_W      = 24;
    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << (8 * CHANNELS)) - 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CROP_LEFT    = 3'd0,
        REG_CROP_TOP     = 3'd1,
        REG_CROP_WIDTH   = 3'd2,
        REG_CROP_HEIGHT  = 3'd3,
        REG_DEST_WIDTH   = 3'd4,
        REG_DEST_HEIGHT  = 3'd5,
        REG_ELLIPSE_MODE = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DIM_W-1:0] crop_left;
        logic signed [DIM_W-1:0] crop_top;
        logic [DIM_W-1:0]        crop_width;
        logic [DIM_W-1:0]        crop_height;
        logic [DIM_W-1:0]        dest_width;
        logic [DIM_W-1:0]        dest_height;
        logic                    ellipse_mode;
    } t_cfg;

endpackage

>>> design/rcem_if.sv
// Handshake channel interfaces for pixel input, result output and register writes.
`timescale 1ns / 1ps

interface rcem_pix_if;
    logic                        valid;
    logic                        ready;
    logic [rcem_pkg::COORD_W-1:0] src_row;
    logic [rcem_pkg::COORD_W-1:0] src_col;
    logic [rcem_pkg::PIX_W-1:0]   pixel_value;

    modport source (output valid, output src_row, output src_col, output pixel_value,
                    input ready);
    modport sink   (input valid, input src_row, input src_col, input pixel_value,
                    output ready);
endinterface

interface rcem_res_if;
    logic                       valid;
    logic                       ready;
    logic                       write_enable;
    logic [rcem_pkg::IDX_W-1:0] dest_index;
    logic [rcem_pkg::PIX_W-1:0] pixel_out;
    logic                       outside_dest;

    modport source (output valid, output write_enable, output dest_index,
                    output pixel_out, output outside_dest, input ready);
    modport sink   (input valid, input write_enable, input dest_index,
                    input pixel_out, input outside_dest, output ready);
endinterface

interface rcem_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rcem_pkg::CFG_IDX_W-1:0]  index;
    logic [rcem_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/rcem_cfg_regs.sv
// Configuration register file written through the register channel.
`timescale 1ns / 1ps

module rcem_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rcem_cfg_if.sink        i_cfg,
    output rcem_pkg::t_cfg  o_cfg
);

    rcem_pkg::t_cfg r_cfg;
    rcem_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (rcem_pkg::t_cfg_reg'(i_cfg.index))
                rcem_pkg::REG_CROP_LEFT:    n_cfg.crop_left    = $signed(i_cfg.data);
                rcem_pkg::REG_CROP_TOP:     n_cfg.crop_top     = $signed(i_cfg.data);
                rcem_pkg::REG_CROP_WIDTH:   n_cfg.crop_width   = i_cfg.data;
                rcem_pkg::REG_CROP_HEIGHT:  n_cfg.crop_height  = i_cfg.data;
                rcem_pkg::REG_DEST_WIDTH:   n_cfg.dest_width   = i_cfg.data;
                rcem_pkg::REG_DEST_HEIGHT:  n_cfg.dest_height  = i_cfg.data;
                rcem_pkg::REG_ELLIPSE_MODE: n_cfg.ellipse_mode = i_cfg.data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crop_left    <= '0;
            r_cfg.crop_top     <= '0;
            r_cfg.crop_width   <= '0;
            r_cfg.crop_height  <= '0;
            r_cfg.dest_width   <= rcem_pkg::DIM_W'(1);
            r_cfg.dest_height  <= rcem_pkg::DIM_W'(1);
            r_cfg.ellipse_mode <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/roi_crop_with_ellipse_mask.sv
// Top level: four-stage pipelined window/ellipse test and destination index mapping.
// A pixel accepted at the input is registered through stages 1 to 4 in order; stage 4 drives its result word.
// Throughput: one pixel per cycle while the output is not stalled; each stage holds one word and loads when it
// is empty or its successor moves, so a stall at the output fills bubbles first.
// The ellipse test runs as squares in stage 2, cross products in stage 3 and
// the sum/compare in stage 4. Reset clears all stage valid bits and returns the
// configuration registers to their reset values; no clearing pass is needed.
`timescale 1ns / 1ps

module roi_crop_with_ellipse_mask (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcem_pix_if.sink  i_pix,
    rcem_res_if.source o_res,
    rcem_cfg_if.sink  i_cfg
);

    rcem_pkg::t_cfg cfg;

    rcem_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || o_res.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_pix.ready = rdy1;

    // stage 1: window offsets and centered doubles
    logic signed [14:0] j_c, i_c;
    logic               sel_c;

    logic                  r_s1_sel;
    logic [12:0]           r_s1_j, r_s1_i;
    logic signed [14:0]    r_s1_dx, r_s1_dy;
    logic [rcem_pkg::PIX_W-1:0] r_s1_pix;

    assign j_c = $signed({3'b000, i_pix.src_col})
               - $signed({{2{cfg.crop_left[12]}}, cfg.crop_left});
    assign i_c = $signed({3'b000, i_pix.src_row})
               - $signed({{2{cfg.crop_top[12]}}, cfg.crop_top});
    assign sel_c = !j_c[14] && (j_c[13:0] < {1'b0, cfg.crop_width})
                && !i_c[14] && (i_c[13:0] < {1'b0, cfg.crop_height});

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_sel <= sel_c;
            r_s1_j   <= j_c[12:0];
            r_s1_i   <= i_c[12:0];
            r_s1_dx  <= $signed({j_c[13:0], 1'b0}) - $signed({2'b00, cfg.crop_width});
            r_s1_dy  <= $signed({i_c[13:0], 1'b0}) - $signed({2'b00, cfg.crop_height});
            r_s1_pix <= i_pix.pixel_value & rcem_pkg::PIX_MASK;
        end
    end

    // stage 2: squares and destination position
    logic signed [29:0] dx_sq, dy_sq;
    logic signed [14:0] dcol_c, drow_c;
    logic               in_dst_c;

    logic        r_s2_sel, r_s2_in_dst;
    logic [25:0] r_s2_dx2, r_s2_dy2, r_s2_w2, r_s2_h2;
    logic [12:0] r_s2_dcol, r_s2_drow;
    logic [rcem_pkg::PIX_W-1:0] r_s2_pix;

    assign dx_sq  = r_s1_dx * r_s1_dx;
    assign dy_sq  = r_s1_dy * r_s1_dy;
    assign dcol_c = $signed({3'b000, cfg.dest_width[12:1]})
                  - $signed({3'b000, cfg.crop_width[12:1]})
                  + $signed({2'b00, r_s1_j});
    assign drow_c = $signed({3'b000, cfg.dest_height[12:1]})
                  - $signed({3'b000, cfg.crop_height[12:1]})
                  + $signed({2'b00, r_s1_i});
    assign in_dst_c = !dcol_c[14] && (dcol_c[13:0] < {1'b0, cfg.dest_width})
                   && !drow_c[14] && (drow_c[13:0] < {1'b0, cfg.dest_height});

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_sel    <= r_s1_sel;
            r_s2_in_dst <= in_dst_c;
            r_s2_dx2    <= dx_sq[25:0];
            r_s2_dy2    <= dy_sq[25:0];
            r_s2_w2     <= cfg.crop_width * cfg.crop_width;
            r_s2_h2     <= cfg.crop_height * cfg.crop_height;
            r_s2_dcol   <= dcol_c[12:0];
            r_s2_drow   <= drow_c[12:0];
            r_s2_pix    <= r_s1_pix;
        end
    end

    // stage 3: cross products and row offset
    logic        r_s3_sel, r_s3_in_dst;
    logic [51:0] r_s3_p1, r_s3_p2, r_s3_p3;
    logic [25:0] r_s3_rowoff;
    logic [12:0] r_s3_dcol;
    logic [rcem_pkg::PIX_W-1:0] r_s3_pix;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_sel    <= r_s2_sel;
            r_s3_in_dst <= r_s2_in_dst;
            r_s3_p1     <= r_s2_dx2 * r_s2_h2;
            r_s3_p2     <= r_s2_dy2 * r_s2_w2;
            r_s3_p3     <= r_s2_w2 * r_s2_h2;
            r_s3_rowoff <= r_s2_drow * cfg.dest_width;
            r_s3_dcol   <= r_s2_dcol;
            r_s3_pix    <= r_s2_pix;
        end
    end

    // stage 4: ellipse compare, index sum, output word
    logic [52:0] ell_sum;
    logic        keep_c, we_c;

    assign ell_sum = {1'b0, r_s3_p1} + {1'b0, r_s3_p2};
    assign keep_c  = r_s3_sel && (!cfg.ellipse_mode || (ell_sum <= {1'b0, r_s3_p3}));
    assign we_c    = keep_c && r_s3_in_dst;

    logic        r_s4_we, r_s4_outside;
    logic [rcem_pkg::IDX_W-1:0] r_s4_idx;
    logic [rcem_pkg::PIX_W-1:0] r_s4_pix;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_we      <= we_c;
            r_s4_outside <= keep_c && !r_s3_in_dst;
            r_s4_idx     <= we_c ? (r_s3_rowoff[rcem_pkg::IDX_W-1:0]
                                    + rcem_pkg::IDX_W'(r_s3_dcol)) : '0;
            r_s4_pix     <= r_s3_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_pix.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign o_res.valid        = r_v4;
    assign o_res.write_enable = r_s4_we;
    assign o_res.dest_index   = r_s4_idx;
    assign o_res.pixel_out    = r_s4_pix;
    assign o_res.outside_dest = r_s4_outside;

endmodule

>>> design/rcem_checker.sv
// Port-level assertions for the ROI crop top level, attached by bind.
`timescale 1ns / 1ps

module rcem_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic                       i_write_enable,
    input logic [rcem_pkg::IDX_W-1:0] i_dest_index,
    input logic                       i_outside_dest
);

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_dest_index))
        else $error("stalled result word dropped or changed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_write_enable && i_outside_dest))
        else $error("write and outside flags both set");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_write_enable |-> i_dest_index == '0)
        else $error("index nonzero without write");

endmodule

bind roi_crop_with_ellipse_mask rcem_checker u_rcem_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_write_enable (o_res.write_enable),
    .i_dest_index   (o_res.dest_index),
    .i_outside_dest (o_res.outside_dest)
);
